// File: design/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, character codes and the hex digit decoder of the URL
// percent decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;

    // Letters a..f / A..F carry their value minus 9 in the low nibble.
    localparam logic [3:0] HEX_ALPHA_ADJ = 4'd9;

    localparam int unsigned BURST_MAX = 3;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Up to three decoded bytes caused by one input word, in output order.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [1:0]                count;
        logic                      last;
    } burst_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = c[3:0];
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h.ok = 1'b1;
        end
        else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) || (c >= CHAR_LC_A && c <= CHAR_LC_F))
        begin
            h.ok  = 1'b1;
            h.val = c[3:0] + HEX_ALPHA_ADJ;
        end
        return h;
    endfunction

endpackage

// File: design/urlpd_front.sv
// ----------------------------------------------------------------------------
// urlpd_front
// Accepts raw bytes, tracks the escape state and turns each word into a
// burst of zero to three decoded bytes for the queue.
// ----------------------------------------------------------------------------
module urlpd_front
    import urlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_ready,
    output logic       q_push,
    output burst_t     q_data
);

    esc_phase_t phase_reg;
    esc_phase_t phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;

    hex_t       cur_hex;
    hex_t       held_hex;
    logic [7:0] mapped;
    logic       is_pct;
    logic       accept;
    burst_t     burst;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign cur_hex  = hex_decode(in_byte);
    assign held_hex = hex_decode(held_reg);
    assign is_pct   = (in_byte == CHAR_PCT);
    assign mapped   = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;

    always_comb
    begin
        burst       = '0;
        burst.last  = in_last;
        phase_next  = ESC_IDLE;
        held_next   = held_reg;

        case (phase_reg)
            ESC_PCT:
            begin
                if (cur_hex.ok) begin
                    phase_next = ESC_DIGIT;
                    held_next  = in_byte;
                end
                else begin
                    burst.bytes[0] = CHAR_PCT;
                    if (is_pct) begin
                        phase_next  = ESC_PCT;
                        burst.count = 2'd1;
                    end
                    else begin
                        burst.bytes[1] = mapped;
                        burst.count    = 2'd2;
                    end
                end
            end
            ESC_DIGIT:
            begin
                held_next = '0;
                if (cur_hex.ok) begin
                    burst.bytes[0] = {held_hex.val, cur_hex.val};
                    burst.count    = 2'd1;
                end
                else begin
                    burst.bytes[0] = CHAR_PCT;
                    burst.bytes[1] = held_reg;
                    if (is_pct) begin
                        phase_next  = ESC_PCT;
                        burst.count = 2'd2;
                    end
                    else begin
                        burst.bytes[2] = mapped;
                        burst.count    = 2'd3;
                    end
                end
            end
            default:
            begin
                if (is_pct) begin
                    phase_next = ESC_PCT;
                end
                else begin
                    burst.bytes[0] = mapped;
                    burst.count    = 2'd1;
                end
            end
        endcase

        // Flush a pending escape at end of string.
        if (in_last) begin
            if (phase_next == ESC_PCT) begin
                case (burst.count)
                    2'd0:    burst.bytes[0] = CHAR_PCT;
                    2'd1:    burst.bytes[1] = CHAR_PCT;
                    default: burst.bytes[2] = CHAR_PCT;
                endcase
                burst.count = burst.count + 2'd1;
            end
            else if (phase_next == ESC_DIGIT) begin
                burst.bytes[0] = CHAR_PCT;
                burst.bytes[1] = in_byte;
                burst.count    = 2'd2;
            end
            phase_next = ESC_IDLE;
            held_next  = '0;
        end
    end

    assign q_push = accept && (burst.count != 2'd0);
    assign q_data = burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= ESC_IDLE;
            held_reg  <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: design/urlpd_queue.sv
// ----------------------------------------------------------------------------
// urlpd_queue
// Short first-in first-out queue of bursts between front and back.
// ----------------------------------------------------------------------------
module urlpd_queue
    import urlpd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_data,
    output logic   not_full,
    input  logic   pop,
    output logic   not_empty,
    output burst_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    burst_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/urlpd_back.sv
// ----------------------------------------------------------------------------
// urlpd_back
// Feeds the head burst to the output register one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module urlpd_back
    import urlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  burst_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic       final_byte;
    logic [7:0] sel_byte;

    assign load       = head_valid && (!out_valid_reg || out_ready);
    assign final_byte = (idx_reg == head.count - 2'd1);
    assign pop        = load && final_byte;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            default: sel_byte = head.bytes[2];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = final_byte ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg <= sel_byte;
            out_last_reg <= head.last && final_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Queue never holds an empty burst.
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> head.count != 2'd0)
        else $error("empty burst at queue head");

    // Byte index stays inside the head burst.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.count)
        else $error("byte index beyond burst");

    // Retiring a burst presents its final byte with the burst's last flag.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && (out_last_reg == $past(head.last)))
        else $error("burst retired without matching last flag");

endmodule

// File: design/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: '%hh' becomes one byte, '+' a space, broken
// escapes pass through literally, pending escapes flush at end of string.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                  | Word
//  --------+------------------------------------------+--------------------
//  input   | in_valid, in_ready, in_byte, in_last     | one encoded byte
//  output  | out_valid, out_ready, out_byte, out_last | one decoded byte
//
//  One input word is taken per cycle while the queue is not full. Each word
//  makes zero to three decoded bytes; the output register drains one byte
//  per cycle while out_ready is high; a burst of n bytes makes n words.
//  A burst is registered in the queue, then byte by byte in the output register.
//  The burst queue (QUEUE_DEPTH entries) decouples the sides: in_ready
//  drops only while the queue is full, independent of out_ready.
//  Reset clears the escape state, queue pointers and output valid.
//
module url_percent_decoder
    import urlpd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    // Front to queue: burst and push strobe; queue to back: head word.
    logic   q_push;
    logic   q_not_full;
    burst_t q_push_data;
    logic   q_pop;
    logic   q_not_empty;
    burst_t q_head;

    // Classify each byte and build its burst.
    urlpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // Hold bursts until the output side has room.
    urlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Advance through the head burst one byte per output word.
    urlpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule
